@@ design/ffha_pkg.sv @@
// Shared constants, codes and control/status types for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_datapath and first_fit_heap_allocator_core; no dependencies.
package ffha_pkg;

  // Arena geometry
  localparam int HEAP_WORDS = 1024;
  localparam int WORD_BYTES = 8;
  localparam int WB_SHIFT   = $clog2(WORD_BYTES);
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int CNT_W      = ADDR_W + 1;

  // Field widths
  localparam int HDR_W    = 12;
  localparam int MAG_W    = HDR_W + 1;
  localparam int CFG_W    = 11;
  localparam int BYTES_W  = 13;
  localparam int NEED_W   = BYTES_W + 1;
  localparam int STATUS_W = 2;

  // Arena size limits
  localparam logic [CFG_W-1:0] ARENA_MIN = CFG_W'(3);
  localparam logic [CFG_W-1:0] ARENA_MAX = CFG_W'(HEAP_WORDS);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Header store write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_SPLIT,
    WR_HEAD_NEED,
    WR_HEAD_RUN,
    WR_FREE
  } wr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic                latch;
    logic                walk_init;
    logic                rd_walk;
    logic                rd_free;
    logic                walk_step;
    wr_sel_t             wr_sel;
    logic                res_set;
    logic [STATUS_W-1:0] res_code;
    logic                res_alloc;
    logic                out_load;
    logic                clr_start;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;
    logic bytes_zero;
    logic payload_null;
    logic free_oob;
    logic fits;
    logic wp_oob;
    logic len_neg;
    logic found_next;
    logic step_bad;
    logic split;
    logic clear_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/ffha_ctrl.sv @@
// Sequencer for the allocator: clearing pass, request decode, header walk, commit.
// Depends on ffha_pkg for command/status types and codes.
module ffha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              cfg_wen,
  input  ffha_pkg::dp_stat_t stat,
  output logic              in_ready,
  output ffha_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_FREAD   = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_EVAL    = 4'd5;
  localparam logic [3:0] S_COMMIT  = 4'd6;
  localparam logic [3:0] S_COMMIT2 = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    cmd.wr_sel = ffha_pkg::WR_NONE;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.wr_sel = ffha_pkg::WR_CLEAR;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_free) begin
          if (stat.bytes_zero) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ffha_pkg::ST_INVALID;
            state_next   = S_DONE;
          end else begin
            cmd.walk_init = 1'b1;
            state_next    = S_CHECK;
          end
        end else if (stat.payload_null) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ffha_pkg::ST_OK;
          state_next   = S_DONE;
        end else if (stat.free_oob) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ffha_pkg::ST_INVALID;
          state_next   = S_DONE;
        end else begin
          cmd.rd_free = 1'b1;
          state_next  = S_FREAD;
        end
      end
      S_FREAD: begin
        cmd.res_set = 1'b1;
        if (!stat.len_neg) begin
          cmd.res_code = ffha_pkg::ST_INVALID;
        end else begin
          cmd.wr_sel   = ffha_pkg::WR_FREE;
          cmd.res_code = ffha_pkg::ST_OK;
        end
        state_next = S_DONE;
      end
      S_CHECK: begin
        if (!stat.fits || stat.wp_oob) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ffha_pkg::ST_NO_SPACE;
          state_next   = S_DONE;
        end else begin
          cmd.rd_walk = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.walk_step = 1'b1;
        if (stat.found_next) begin
          state_next = S_COMMIT;
        end else if (stat.step_bad) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ffha_pkg::ST_NO_SPACE;
          state_next   = S_DONE;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_COMMIT: begin
        if (stat.split) begin
          cmd.wr_sel = ffha_pkg::WR_SPLIT;
          state_next = S_COMMIT2;
        end else begin
          cmd.wr_sel    = ffha_pkg::WR_HEAD_RUN;
          cmd.res_set   = 1'b1;
          cmd.res_code  = ffha_pkg::ST_OK;
          cmd.res_alloc = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_COMMIT2: begin
        cmd.wr_sel    = ffha_pkg::WR_HEAD_NEED;
        cmd.res_set   = 1'b1;
        cmd.res_code  = ffha_pkg::ST_OK;
        cmd.res_alloc = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase

    // Arena size write restarts the clearing pass
    if (cfg_wen) begin
      cmd           = '0;
      cmd.wr_sel    = ffha_pkg::WR_NONE;
      cmd.clr_start = 1'b1;
      state_next    = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/ffha_datapath.sv @@
// Datapath: header store, walk registers, arena size register and result output stage.
// Depends on ffha_pkg; driven by ffha_ctrl commands.
module ffha_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [ffha_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              opcode,
  input  logic [ffha_pkg::BYTES_W-1:0]      request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]       payload_word,
  input  logic                              out_stall,
  input  ffha_pkg::dp_cmd_t                 cmd,
  output ffha_pkg::dp_stat_t                stat,
  output logic                              out_valid,
  output logic [ffha_pkg::STATUS_W-1:0]     status,
  output logic [ffha_pkg::ADDR_W-1:0]       alloc_word
);

  localparam int ADDR_W = ffha_pkg::ADDR_W;
  localparam int CNT_W  = ffha_pkg::CNT_W;
  localparam int HDR_W  = ffha_pkg::HDR_W;
  localparam int MAG_W  = ffha_pkg::MAG_W;
  localparam int CFG_W  = ffha_pkg::CFG_W;
  localparam int NEED_W = ffha_pkg::NEED_W;
  localparam int SUM_W  = NEED_W + 1;

  // Header store
  logic [HDR_W-1:0] mem [ffha_pkg::HEAP_WORDS];
  logic [HDR_W-1:0] rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [HDR_W-1:0]  wr_data;

  // Configuration and clearing
  logic [CFG_W-1:0]  arena;
  logic [CFG_W-1:0]  arena_next;
  logic [ADDR_W-1:0] clr_cnt;

  // Latched request
  logic                        req_op;
  logic [ffha_pkg::BYTES_W-1:0] req_bytes;
  logic [ADDR_W-1:0]           req_payload;

  // Walk registers
  logic [NEED_W-1:0] need;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  wp;
  logic [ADDR_W-1:0] rs;
  logic [NEED_W-1:0] rl;

  // Result holding and output registers
  logic [ffha_pkg::STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]             res_word;

  logic [NEED_W-1:0] bytes_up;
  logic [NEED_W-1:0] need_calc;
  logic [ADDR_W-1:0] free_hdr;
  logic              len_neg;
  logic [MAG_W-1:0]  mag;
  logic [NEED_W-1:0] rl_new;
  logic [ADDR_W-1:0] rs_new;
  logic [SUM_W-1:0]  split_addr;
  logic              split_ok;

  // Arena size write, clamped to the legal range
  always_comb begin
    arena_next = cfg_wdata;
    if (cfg_wdata > ffha_pkg::ARENA_MAX) arena_next = ffha_pkg::ARENA_MAX;
    if (cfg_wdata < ffha_pkg::ARENA_MIN) arena_next = ffha_pkg::ARENA_MIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arena   <= ffha_pkg::ARENA_MAX;
      clr_cnt <= '0;
    end else begin
      if (cfg_wen) arena <= arena_next;
      if (cmd.clr_start) begin
        clr_cnt <= '0;
      end else if (cmd.wr_sel == ffha_pkg::WR_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  // Request decode
  assign bytes_up  = NEED_W'(req_bytes) + NEED_W'(ffha_pkg::WORD_BYTES - 1);
  assign need_calc = (bytes_up >> ffha_pkg::WB_SHIFT) + NEED_W'(1);
  assign free_hdr  = req_payload - ADDR_W'(1);

  // One header step
  assign len_neg = rdata[HDR_W-1];
  assign mag     = len_neg ? (MAG_W'(0) - {1'b1, rdata}) : {1'b0, rdata};
  assign rl_new  = len_neg ? '0 : (rl + NEED_W'(rdata));
  assign rs_new  = len_neg ? '0 : ((rl == '0) ? wp[ADDR_W-1:0] : rs);

  assign split_addr = SUM_W'(rs) + SUM_W'(need);
  assign split_ok   = (split_addr < SUM_W'(ffha_pkg::HEAP_WORDS));

  // Status toward the controller
  always_comb begin
    stat              = '0;
    stat.is_free      = (req_op == ffha_pkg::OP_FREE);
    stat.bytes_zero   = (req_bytes == '0);
    stat.payload_null = (req_payload == '0);
    stat.free_oob     = (CFG_W'(free_hdr) >= arena);
    stat.fits         = (SUM_W'(total) + SUM_W'(rl)) >= SUM_W'(need);
    stat.wp_oob       = (wp >= CNT_W'(ffha_pkg::HEAP_WORDS));
    stat.len_neg      = len_neg;
    stat.found_next   = !len_neg && (rl_new >= need);
    stat.step_bad     = (mag == '0) || (mag > MAG_W'(total));
    stat.split        = (rl > need);
    stat.clear_last   = (clr_cnt == ADDR_W'(ffha_pkg::HEAP_WORDS - 1));
    stat.out_free     = !out_valid || !out_stall;
  end

  // Request and walk registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_op      <= opcode;
      req_bytes   <= request_bytes;
      req_payload <= payload_word;
    end
    if (cmd.walk_init) begin
      need  <= need_calc;
      total <= arena - CFG_W'(1);
      wp    <= CNT_W'(1);
      rs    <= '0;
      rl    <= '0;
    end else if (cmd.walk_step) begin
      rs    <= rs_new;
      rl    <= rl_new;
      total <= CNT_W'(total - mag);
      wp    <= CNT_W'(wp + mag);
    end
  end

  // Header store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rs;
    wr_data = '0;
    case (cmd.wr_sel)
      ffha_pkg::WR_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = (clr_cnt == ADDR_W'(1)) ? HDR_W'(arena - CFG_W'(1)) : '0;
      end
      ffha_pkg::WR_SPLIT: begin
        wr_en   = split_ok;
        wr_addr = split_addr[ADDR_W-1:0];
        wr_data = HDR_W'(rl - need);
      end
      ffha_pkg::WR_HEAD_NEED: begin
        wr_en   = 1'b1;
        wr_data = HDR_W'(NEED_W'(0) - need);
      end
      ffha_pkg::WR_HEAD_RUN: begin
        wr_en   = 1'b1;
        wr_data = HDR_W'(NEED_W'(0) - rl);
      end
      ffha_pkg::WR_FREE: begin
        wr_en   = 1'b1;
        wr_addr = free_hdr;
        wr_data = HDR_W'(0) - rdata;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = cmd.rd_walk ? wp[ADDR_W-1:0] : free_hdr;

  // Header store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_walk || cmd.rd_free) rdata <= mem[rd_addr];
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_word   <= cmd.res_alloc ? (rs + ADDR_W'(1)) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= res_status;
      alloc_word <= res_word;
    end
  end

endmodule

@@ design/first_fit_heap_allocator_core.sv @@
// Top level of the first-fit heap allocator: joins the controller and the datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_datapath.
//
//   channel  handshake             payload
//   -------  --------------------  --------------------------------------
//   cfg      cfg_wen               cfg_wdata (arena size in words)
//   in       in_valid / in_stall   opcode, request_bytes, payload_word
//   out      out_valid / out_stall status, alloc_word
//
// One request at a time. An allocate walks the headers (a read through the store's
// single read port, then an evaluate), then writes its header, after the remainder's
// when the run is split; a free reads one header and, if in use, marks it free;
// zero-byte allocates and null or out-of-arena frees end at decode. Reset and each
// arena size write start a clearing pass of the whole header store; in_stall is high
// until it ends. A stalled result sits in the output register while the next request is taken.
module first_fit_heap_allocator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [ffha_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [ffha_pkg::BYTES_W-1:0]      request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]       payload_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ffha_pkg::STATUS_W-1:0]     status,
  output logic [ffha_pkg::ADDR_W-1:0]       alloc_word
);

  ffha_pkg::dp_cmd_t  cmd;
  ffha_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_stall = !in_ready;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cfg_wen  (cfg_wen),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ffha_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .opcode        (opcode),
    .request_bytes (request_bytes),
    .payload_word  (payload_word),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .status        (status),
    .alloc_word    (alloc_word)
  );

endmodule
